// File: design/pzs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pzs_pkg
// Shared types for the pairs z-score signal unit: the multiply step codes, the
// register and position codes, and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package pzs_pkg;

  localparam int SIDX_W    = 3;
  localparam int PRICE_W   = 32;
  localparam int NUM_PORTS = 8;

  // One code per product taken in the per-pair update, in issue order.
  typedef enum logic [3:0] {
    OP_MF  = 4'd0,
    OP_MS  = 4'd1,
    OP_SQ1 = 4'd2,
    OP_WV1 = 4'd3,
    OP_AV1 = 4'd4,
    OP_DD  = 4'd5,
    OP_AC  = 4'd6,
    OP_WC  = 4'd7,
    OP_BX  = 4'd8,
    OP_SM  = 4'd9,
    OP_SQ2 = 4'd10,
    OP_WV2 = 4'd11,
    OP_AV2 = 4'd12
  } mop_t;

  typedef enum logic [1:0] {
    CFG_SMOOTH = 2'd0,
    CFG_FLOOR  = 2'd1,
    CFG_ENTRY  = 2'd2,
    CFG_EXIT   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    POS_HOLD = 2'd0,
    POS_BUY  = 2'd1,
    POS_SELL = 2'd2
  } pos_t;

  typedef struct packed {
    logic              capture;
    logic              rd_mem;
    logic              rd_j;
    logic              diff;
    logic              mul_start;
    logic              mul_apply;
    logic              div_start;
    logic              div_apply;
    logic              div_z;
    logic              sqrt_start;
    logic              finish;
    mop_t              op;
    logic [SIDX_W-1:0] first;
    logic [SIDX_W-1:0] second;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic div_busy;
    logic sqrt_busy;
    logic out_free;
  } sts_t;

endpackage

// File: design/pairs_zscore_signal_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pairs_zscore_signal_unit
// Pairs-trading signal: per-pair exponentially weighted statistics, hedge
// ratio, spread z-score and a hold/buy/sell hysteresis position.
// ----------------------------------------------------------------------------
// Each accepted tick of NUM_STOCKS prices yields one result beat per pair
// (i<j) in the order (0,1),(0,2),...; the final beat of a tick has
// out_last_pair set. Pairs are processed one at a time; each pair update
// reads the record and forms the deltas, takes thirteen products on one
// shared 32x32 multiplier, runs two 88-step restoring divisions (hedge ratio
// and z-score) and a 32-step square root, and then writes the record back
// and loads the output register once that register is free. A new tick is
// taken once the last pair of the previous one has been placed in the output
// register. The pair store is cleared at reset through per-entry valid bits,
// so no clearing pass is needed. Configuration writes take effect at once and
// are meant for idle periods.
module pairs_zscore_signal_unit import pzs_pkg::*; #(
  parameter int NUM_STOCKS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [PRICE_W-1:0]  in_price_0,
  input  logic [PRICE_W-1:0]  in_price_1,
  input  logic [PRICE_W-1:0]  in_price_2,
  input  logic [PRICE_W-1:0]  in_price_3,
  input  logic [PRICE_W-1:0]  in_price_4,
  input  logic [PRICE_W-1:0]  in_price_5,
  input  logic [PRICE_W-1:0]  in_price_6,
  input  logic [PRICE_W-1:0]  in_price_7,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SIDX_W-1:0]   out_first_stock,
  output logic [SIDX_W-1:0]   out_second_stock,
  output logic [1:0]          out_position,
  output logic signed [23:0]  out_z_score,
  output logic signed [31:0]  out_hedge_ratio,
  output logic                out_last_pair
);

  localparam int PAIRS = NUM_STOCKS * (NUM_STOCKS - 1) / 2;
  localparam int KW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;

  logic [PRICE_W-1:0] price [NUM_PORTS];
  cmd_t               cmd;
  sts_t               sts;
  logic [KW-1:0]      pair_idx;

  assign price[0] = in_price_0;
  assign price[1] = in_price_1;
  assign price[2] = in_price_2;
  assign price[3] = in_price_3;
  assign price[4] = in_price_4;
  assign price[5] = in_price_5;
  assign price[6] = in_price_6;
  assign price[7] = in_price_7;

  pzs_ctrl #(
    .NUM_STOCKS (NUM_STOCKS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd),
    .pair_idx (pair_idx)
  );

  pzs_dp #(
    .NUM_STOCKS (NUM_STOCKS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_price         (price),
    .cmd              (cmd),
    .pair_idx         (pair_idx),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_first_stock  (out_first_stock),
    .out_second_stock (out_second_stock),
    .out_position     (out_position),
    .out_z_score      (out_z_score),
    .out_hedge_ratio  (out_hedge_ratio),
    .out_last_pair    (out_last_pair)
  );

endmodule

// File: design/pzs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pzs_ctrl
// Sequencer that walks the pairs of one tick and steps the datapath through
// the multiply, divide and square root phases of each pair update.
// ----------------------------------------------------------------------------
module pzs_ctrl import pzs_pkg::*; #(
  parameter int NUM_STOCKS = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd,
  output logic [((NUM_STOCKS*(NUM_STOCKS-1)/2) > 1 ?
                 $clog2(NUM_STOCKS*(NUM_STOCKS-1)/2) : 1)-1:0] pair_idx
);

  localparam int PAIRS = NUM_STOCKS * (NUM_STOCKS - 1) / 2;
  localparam int KW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam logic [SIDX_W-1:0] LAST_I = SIDX_W'(NUM_STOCKS - 2);
  localparam logic [SIDX_W-1:0] LAST_J = SIDX_W'(NUM_STOCKS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_READJ, S_DIFF, S_MUL, S_MWAIT, S_POST,
    S_DIV, S_DWAIT, S_DPOST, S_SQRT, S_SWAIT, S_FINISH
  } state_t;

  state_t            state_r;
  mop_t              op_r;
  logic              divz_r;
  logic [SIDX_W-1:0] i_r;
  logic [SIDX_W-1:0] j_r;
  logic [KW-1:0]     k_r;
  logic              pair_last;

  assign pair_last = (i_r == LAST_I);
  assign in_ready  = (state_r == S_IDLE);
  assign pair_idx  = k_r;

  always_comb begin
    cmd            = '0;
    cmd.op         = op_r;
    cmd.first      = i_r;
    cmd.second     = j_r;
    cmd.last       = pair_last;
    cmd.div_z      = divz_r;
    cmd.capture    = in_valid && (state_r == S_IDLE);
    cmd.rd_mem     = (state_r == S_READ);
    cmd.rd_j       = (state_r == S_READJ);
    cmd.diff       = (state_r == S_DIFF);
    cmd.mul_start  = (state_r == S_MUL);
    cmd.mul_apply  = (state_r == S_POST);
    cmd.div_start  = (state_r == S_DIV);
    cmd.div_apply  = (state_r == S_DPOST);
    cmd.sqrt_start = (state_r == S_SQRT);
    cmd.finish     = (state_r == S_FINISH) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_MF;
      divz_r  <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            i_r     <= '0;
            j_r     <= SIDX_W'(1);
            k_r     <= '0;
            state_r <= S_READ;
          end
        end
        S_READ:  state_r <= S_READJ;
        S_READJ: state_r <= S_DIFF;
        S_DIFF: begin
          op_r    <= OP_MF;
          state_r <= S_MUL;
        end
        S_MUL:   state_r <= S_MWAIT;
        S_MWAIT: begin
          if (!sts.mul_busy) state_r <= S_POST;
        end
        S_POST: begin
          if (op_r == OP_WC) begin
            divz_r  <= 1'b0;
            state_r <= S_DIV;
          end else if (op_r == OP_AV2) begin
            state_r <= S_SQRT;
          end else begin
            op_r    <= mop_t'(op_r + 4'd1);
            state_r <= S_MUL;
          end
        end
        S_DIV:   state_r <= S_DWAIT;
        S_DWAIT: begin
          if (!sts.div_busy) state_r <= S_DPOST;
        end
        S_DPOST: begin
          if (!divz_r) begin
            op_r    <= OP_BX;
            state_r <= S_MUL;
          end else begin
            state_r <= S_FINISH;
          end
        end
        S_SQRT:  state_r <= S_SWAIT;
        S_SWAIT: begin
          if (!sts.sqrt_busy) begin
            divz_r  <= 1'b1;
            state_r <= S_DIV;
          end
        end
        S_FINISH: begin
          if (sts.out_free) begin
            k_r <= k_r + KW'(1);
            if (pair_last) begin
              state_r <= S_IDLE;
            end else begin
              if (j_r == LAST_J) begin
                i_r <= i_r + SIDX_W'(1);
                j_r <= i_r + SIDX_W'(2);
              end else begin
                j_r <= j_r + SIDX_W'(1);
              end
              state_r <= S_READ;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/pzs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pzs_dp
// Datapath: configuration registers, per-pair record memory, a shared 32x32
// multiplier taking four partial products per product, a restoring divider,
// an integer square root unit and the result register.
// ----------------------------------------------------------------------------
module pzs_dp import pzs_pkg::*; #(
  parameter int NUM_STOCKS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic [PRICE_W-1:0]   in_price [NUM_PORTS],
  input  cmd_t                 cmd,
  input  logic [((NUM_STOCKS*(NUM_STOCKS-1)/2) > 1 ?
                 $clog2(NUM_STOCKS*(NUM_STOCKS-1)/2) : 1)-1:0] pair_idx,
  output sts_t                 sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SIDX_W-1:0]    out_first_stock,
  output logic [SIDX_W-1:0]    out_second_stock,
  output logic [1:0]           out_position,
  output logic signed [23:0]   out_z_score,
  output logic signed [31:0]   out_hedge_ratio,
  output logic                 out_last_pair
);

  localparam int PAIRS     = NUM_STOCKS * (NUM_STOCKS - 1) / 2;
  localparam int DIV_STEPS = 88;
  localparam logic [6:0] DIV_LAST = 7'(DIV_STEPS - 1);
  localparam logic [4:0] SQRT_LAST = 5'd31;
  localparam logic [2:0] MUL_LAST = 3'd4;
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef struct packed {
    logic [47:0] mf;
    logic [47:0] ms;
    logic [63:0] vs2;
    logic [63:0] cov;
    logic [47:0] smn;
    logic [63:0] svar;
    logic [1:0]  pos;
  } rec_t;

  function automatic logic [47:0] clamp48(input logic signed [63:0] v);
    if (v > 64'sh0000_7FFF_FFFF_FFFF) return 48'h7FFF_FFFF_FFFF;
    else if (v < 64'shFFFF_8000_0000_0000) return 48'h8000_0000_0000;
    return v[47:0];
  endfunction

  function automatic logic [63:0] sadd64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    return s[63:0];
  endfunction

  function automatic logic [63:0] uadd64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // Configuration.
  logic [15:0] alpha_r;
  logic [31:0] floor_r;
  logic [23:0] ent_r;
  logic [23:0] ext_r;
  logic [16:0] w_val;

  assign w_val = ONE_Q16 - {1'b0, alpha_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= 16'd655;
      floor_r <= 32'd4295;
      ent_r   <= 24'd131072;
      ext_r   <= 24'd32768;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SMOOTH: alpha_r <= cfg_data[15:0];
        CFG_FLOOR:  floor_r <= cfg_data;
        CFG_ENTRY:  ent_r   <= cfg_data[23:0];
        CFG_EXIT:   ext_r   <= cfg_data[23:0];
      endcase
    end
  end

  // Tick prices and the pair record store.
  logic [PRICE_W-1:0] price_r [NUM_PORTS];
  rec_t               mem [PAIRS];
  logic [PAIRS-1:0]   vld_r;
  rec_t               rdat_r;
  logic               rvld_r;
  rec_t               rec;
  logic [SIDX_W-1:0]  psel;

  assign psel = cmd.rd_j ? cmd.second : cmd.first;
  assign rec  = rvld_r ? rdat_r : '0;

  // Working registers of one pair.
  logic [39:0]        xi_r, xj_r;
  logic signed [47:0] mf_r, ms_r, smn_r, ds_r;
  logic [63:0]        vs2_r, svar_r, cov_r, sq_r, t1_r, t2_r;
  logic [1:0]         pos_r;
  logic signed [48:0] di_r, dj_r;
  logic signed [31:0] beta_r;
  logic signed [23:0] z_r;

  logic [48:0] di_m, dj_m;
  logic [47:0] ds_m;
  logic [63:0] cov_m, t1_m;
  logic [31:0] beta_m;

  assign di_m   = di_r[48] ? 49'(-di_r) : di_r;
  assign dj_m   = dj_r[48] ? 49'(-dj_r) : dj_r;
  assign ds_m   = ds_r[47] ? 48'(-ds_r) : ds_r;
  assign cov_m  = cov_r[63] ? 64'(-cov_r) : cov_r;
  assign t1_m   = t1_r[63] ? 64'(-t1_r) : t1_r;
  assign beta_m = beta_r[31] ? 32'(-beta_r) : beta_r;

  // Multiplier.
  logic [63:0]  ma, mb;
  logic         mn;
  logic [63:0]  ma_r, mb_r;
  logic         mneg_r;
  logic [2:0]   mcnt_r;
  logic         mbusy_r, ppv_r;
  logic [63:0]  pp_r;
  logic [1:0]   ppsh_r;
  logic [127:0] acc_r, pp_sh, prod_sh;
  logic [63:0]  ru, rs_mag, s_res;

  always_comb begin
    ma = '0;
    mb = '0;
    mn = 1'b0;
    case (cmd.op)
      OP_MF:  begin ma = 64'(alpha_r); mb = 64'(di_m); mn = di_r[48]; end
      OP_MS:  begin ma = 64'(alpha_r); mb = 64'(dj_m); mn = dj_r[48]; end
      OP_SQ1: begin ma = 64'(dj_m); mb = 64'(dj_m); end
      OP_WV1: begin ma = 64'(w_val); mb = vs2_r; end
      OP_AV1: begin ma = 64'(alpha_r); mb = sq_r; end
      OP_DD:  begin ma = 64'(di_m); mb = 64'(dj_m); mn = di_r[48] ^ dj_r[48]; end
      OP_AC:  begin ma = 64'(alpha_r); mb = t1_m; mn = t1_r[63]; end
      OP_WC:  begin ma = 64'(w_val); mb = cov_m; mn = cov_r[63]; end
      OP_BX:  begin ma = 64'(beta_m); mb = 64'(xj_r); mn = beta_r[31]; end
      OP_SM:  begin ma = 64'(alpha_r); mb = 64'(ds_m); mn = ds_r[47]; end
      OP_SQ2: begin ma = 64'(ds_m); mb = 64'(ds_m); end
      OP_WV2: begin ma = 64'(w_val); mb = svar_r; end
      OP_AV2: begin ma = 64'(alpha_r); mb = sq_r; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign pp_sh = 128'(pp_r) << {ppsh_r, 5'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
      ppv_r   <= 1'b0;
    end else if (cmd.mul_start) begin
      ma_r    <= ma;
      mb_r    <= mb;
      mneg_r  <= mn;
      acc_r   <= '0;
      mcnt_r  <= '0;
      ppv_r   <= 1'b0;
      mbusy_r <= 1'b1;
    end else if (mbusy_r) begin
      if (mcnt_r != MUL_LAST) begin
        pp_r   <= (mcnt_r[1] ? ma_r[63:32] : ma_r[31:0]) *
                  (mcnt_r[0] ? mb_r[63:32] : mb_r[31:0]);
        ppsh_r <= {1'b0, mcnt_r[1]} + {1'b0, mcnt_r[0]};
        ppv_r  <= 1'b1;
      end else begin
        ppv_r   <= 1'b0;
        mbusy_r <= 1'b0;
      end
      if (ppv_r) acc_r <= acc_r + pp_sh;
      mcnt_r <= mcnt_r + 3'd1;
    end
  end

  always_comb begin
    case (cmd.op)
      OP_SQ1, OP_DD, OP_SQ2: prod_sh = acc_r >> 32;
      OP_BX:                 prod_sh = acc_r >> 24;
      default:               prod_sh = acc_r >> 16;
    endcase
    ru     = (|prod_sh[127:64]) ? '1 : prod_sh[63:0];
    rs_mag = ru[63] ? 64'h7FFF_FFFF_FFFF_FFFF : ru;
    s_res  = mneg_r ? 64'(-rs_mag) : rs_mag;
  end

  logic [47:0] mf_add, ms_add, smn_add, spread_c, ds_c;

  always_comb begin
    mf_add   = clamp48($signed(64'(mf_r)) + $signed(s_res));
    ms_add   = clamp48($signed(64'(ms_r)) + $signed(s_res));
    smn_add  = clamp48($signed(64'(smn_r)) + $signed(s_res));
    spread_c = clamp48($signed({24'b0, xi_r}) - $signed(s_res));
    ds_c     = clamp48($signed(64'($signed(spread_c))) - $signed(64'(smn_r)));
  end

  // Floored variances.
  logic [63:0] flo, vsf1, vsf2;
  logic [31:0] sd;

  assign flo  = {32'b0, floor_r};
  assign vsf1 = (vs2_r > flo) ? vs2_r : ((flo == '0) ? 64'd1 : flo);
  assign vsf2 = (svar_r > flo) ? svar_r : ((flo == '0) ? 64'd1 : flo);

  // Divider and square root.
  logic [87:0] dvd_r;
  logic [63:0] dvs_r, rem_r;
  logic [31:0] q_r;
  logic        qovf_r, dbusy_r;
  logic [6:0]  dcnt_r;
  logic [64:0] rem_sh;
  logic        d_ge;

  logic [63:0] sv_r, sres_r, sbit_r, s_try;
  logic [4:0]  scnt_r;
  logic        sbusy_r;

  assign rem_sh = {rem_r, dvd_r[87]};
  assign d_ge   = (rem_sh >= {1'b0, dvs_r});
  assign s_try  = sres_r + sbit_r;
  assign sd     = (sres_r[31:0] == '0) ? 32'd1 : sres_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
    end else if (cmd.div_start) begin
      dvd_r   <= cmd.div_z ? {32'b0, ds_m, 8'b0} : {cov_m, 24'b0};
      dvs_r   <= cmd.div_z ? {32'b0, sd} : vsf1;
      rem_r   <= '0;
      q_r     <= '0;
      qovf_r  <= 1'b0;
      dcnt_r  <= '0;
      dbusy_r <= 1'b1;
    end else if (dbusy_r) begin
      rem_r  <= d_ge ? 64'(rem_sh - {1'b0, dvs_r}) : rem_sh[63:0];
      dvd_r  <= {dvd_r[86:0], 1'b0};
      q_r    <= {q_r[30:0], d_ge};
      qovf_r <= qovf_r | q_r[31];
      dcnt_r <= dcnt_r + 7'd1;
      if (dcnt_r == DIV_LAST) dbusy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sbusy_r <= 1'b0;
    end else if (cmd.sqrt_start) begin
      sv_r    <= vsf2;
      sres_r  <= '0;
      sbit_r  <= 64'h4000_0000_0000_0000;
      scnt_r  <= '0;
      sbusy_r <= 1'b1;
    end else if (sbusy_r) begin
      if (sv_r >= s_try) begin
        sv_r   <= sv_r - s_try;
        sres_r <= (sres_r >> 1) + sbit_r;
      end else begin
        sres_r <= sres_r >> 1;
      end
      sbit_r <= sbit_r >> 2;
      scnt_r <= scnt_r + 5'd1;
      if (scnt_r == SQRT_LAST) sbusy_r <= 1'b0;
    end
  end

  logic beta_sat, zsat_p, zsat_n;

  assign beta_sat = qovf_r | q_r[31];
  assign zsat_p   = qovf_r | (|q_r[31:23]);
  assign zsat_n   = qovf_r | (|q_r[31:24]) | (q_r[23] & (|q_r[22:0]));

  // Position hysteresis.
  logic signed [25:0] zx, entx, extx;
  logic [1:0]         newpos;

  assign zx   = 26'(z_r);
  assign entx = $signed({2'b0, ent_r});
  assign extx = $signed({2'b0, ext_r});

  always_comb begin
    case (pos_t'(pos_r))
      POS_BUY:  newpos = (zx > -extx) ? POS_HOLD : POS_BUY;
      POS_SELL: newpos = (zx < extx) ? POS_HOLD : POS_SELL;
      default: begin
        if (zx > entx)       newpos = POS_SELL;
        else if (zx < -entx) newpos = POS_BUY;
        else                 newpos = POS_HOLD;
      end
    endcase
  end

  // Pair record handling and per-step updates.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int n = 0; n < NUM_PORTS; n++) price_r[n] <= in_price[n];
    end
    if (cmd.rd_mem) begin
      xi_r   <= {price_r[psel], 8'b0};
      rdat_r <= mem[pair_idx];
      rvld_r <= vld_r[pair_idx];
    end
    if (cmd.rd_j) xj_r <= {price_r[psel], 8'b0};
    if (cmd.diff) begin
      mf_r   <= rec.mf;
      ms_r   <= rec.ms;
      vs2_r  <= rec.vs2;
      cov_r  <= rec.cov;
      smn_r  <= rec.smn;
      svar_r <= rec.svar;
      pos_r  <= rec.pos;
      di_r   <= $signed({9'b0, xi_r}) - $signed({rec.mf[47], rec.mf});
      dj_r   <= $signed({9'b0, xj_r}) - $signed({rec.ms[47], rec.ms});
    end
    if (cmd.mul_apply) begin
      case (cmd.op)
        OP_MF:  mf_r   <= mf_add;
        OP_MS:  ms_r   <= ms_add;
        OP_SQ1: sq_r   <= ru;
        OP_WV1: t1_r   <= ru;
        OP_AV1: vs2_r  <= uadd64(t1_r, ru);
        OP_DD:  t1_r   <= s_res;
        OP_AC:  t2_r   <= s_res;
        OP_WC:  cov_r  <= sadd64(s_res, t2_r);
        OP_BX:  ds_r   <= ds_c;
        OP_SM:  smn_r  <= smn_add;
        OP_SQ2: sq_r   <= ru;
        OP_WV2: t1_r   <= ru;
        OP_AV2: svar_r <= uadd64(t1_r, ru);
        default: t2_r  <= t2_r;
      endcase
    end
    if (cmd.div_apply) begin
      if (!cmd.div_z) begin
        if (cov_r[63]) beta_r <= beta_sat ? 32'sh8000_0000 : 32'(-q_r);
        else           beta_r <= beta_sat ? 32'sh7FFF_FFFF : q_r;
      end else begin
        if (ds_r[47]) z_r <= zsat_n ? 24'sh80_0000 : 24'(-q_r[23:0]);
        else          z_r <= zsat_p ? 24'sh7F_FFFF : q_r[23:0];
      end
    end
    if (cmd.finish) begin
      mem[pair_idx]    <= '{mf: mf_r, ms: ms_r, vs2: vs2_r, cov: cov_r,
                            smn: smn_r, svar: svar_r, pos: newpos};
      out_first_stock  <= cmd.first;
      out_second_stock <= cmd.second;
      out_position     <= newpos;
      out_z_score      <= z_r;
      out_hedge_ratio  <= beta_r;
      out_last_pair    <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        vld_r[pair_idx] <= 1'b1;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.mul_busy  = mbusy_r;
  assign sts.div_busy  = dbusy_r;
  assign sts.sqrt_busy = sbusy_r;
  assign sts.out_free  = !out_valid || out_ready;

endmodule
